// ----- rtl/core/arpc_pkg.sv -----
package arpc_pkg;

    // Default number of cache slots
    localparam int unsigned ENTRIES_DEF = 8;

    // Field widths
    localparam int unsigned IP_W    = 32;
    localparam int unsigned MAC_W   = 48;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned ENTRY_W = IP_W + MAC_W + STAMP_W;

    // Reset value of the expiry limit, in seconds
    localparam logic [STAMP_W-1:0] MAX_AGE_RST = STAMP_W'(43200);

    // Item opcodes
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_LEARN  = 1'b1
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_IP      = 2'd0,
        CFG_SUBNET_MASK = 2'd1,
        CFG_GATEWAY_IP  = 2'd2,
        CFG_MAX_AGE     = 2'd3
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch input beat
        logic learn;     // write slot under fill pointer
        logic setup;     // pick address to resolve, start scan
        logic scan;      // evaluate current slot
        logic load_out;  // move result into output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic match;     // current slot matches resolved address
        logic last;      // current slot is the final one
    } t_sts;

endpackage

// ----- rtl/core/arpc_ram.sv -----
module arpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/arpc_dp.sv -----
module arpc_dp #(
    parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write
    input  logic                                i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    // input beat payload
    input  logic [arpc_pkg::IP_W-1:0]           i_query_ip,
    input  logic [arpc_pkg::MAC_W-1:0]          i_learn_mac,
    input  logic [arpc_pkg::STAMP_W-1:0]        i_now_sec,
    // control
    input  arpc_pkg::t_cmd                      i_cmd,
    output arpc_pkg::t_sts                      o_sts,
    // result payload
    output logic                                o_hit,
    output logic                                o_send_request,
    output logic [arpc_pkg::IP_W-1:0]           o_resolve_ip,
    output logic [arpc_pkg::MAC_W-1:0]          o_found_mac
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned IPW = arpc_pkg::IP_W;
    localparam int unsigned MW  = arpc_pkg::MAC_W;
    localparam int unsigned SW  = arpc_pkg::STAMP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // Configuration registers
    logic [IPW-1:0] r_own_ip;
    logic [IPW-1:0] r_subnet_mask;
    logic [IPW-1:0] r_gateway_ip;
    logic [SW-1:0]  r_max_age;

    // Captured input beat
    logic [IPW-1:0] r_qip;
    logic [MW-1:0]  r_mac;
    logic [SW-1:0]  r_now;

    // Slot bookkeeping
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_ptr;
    logic [IW-1:0]      r_idx;

    // Working result
    logic [IPW-1:0] r_target;
    logic           r_hit;
    logic           r_miss;
    logic [MW-1:0]  r_fmac;

    // Output register
    logic           r_out_hit;
    logic           r_out_req;
    logic [IPW-1:0] r_out_ip;
    logic [MW-1:0]  r_out_mac;

    // RAM signals
    logic [arpc_pkg::ENTRY_W-1:0] ram_wdata;
    logic [arpc_pkg::ENTRY_W-1:0] ram_rdata;
    logic [IW-1:0]                ram_raddr;
    logic                         ram_re;

    // Current slot as seen by the scan
    logic [IPW-1:0] slot_ip;
    logic [MW-1:0]  slot_mac;
    logic [SW-1:0]  slot_stamp;
    logic [SW-1:0]  slot_age;
    logic           slot_expire;
    logic [IPW-1:0] live_ip;
    logic [MW-1:0]  live_mac;
    logic           on_subnet;
    logic           is_last;

    assign ram_wdata = {r_qip, r_mac, r_now};

    // Read slot 0 on setup, then one slot ahead of the one under evaluation
    always_comb begin
        ram_re    = i_cmd.setup | i_cmd.scan;
        ram_raddr = '0;
        if (i_cmd.scan && !is_last) begin
            ram_raddr = r_idx + IW'(1);
        end
    end

    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.learn),
        .i_waddr (r_ptr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Slot evaluation: invalid slots read as zero, aged slots drop out
    always_comb begin
        if (r_valid[r_idx]) begin
            {slot_ip, slot_mac, slot_stamp} = ram_rdata;
        end else begin
            slot_ip    = '0;
            slot_mac   = '0;
            slot_stamp = '0;
        end
        slot_age    = r_now - slot_stamp;
        slot_expire = slot_age > r_max_age;
        live_ip     = slot_expire ? '0 : slot_ip;
        live_mac    = slot_expire ? '0 : slot_mac;
    end

    assign is_last   = (r_idx == LAST_IDX);
    assign on_subnet = (((r_qip ^ r_own_ip) & r_subnet_mask) == '0);

    assign o_sts.match = (live_ip == r_target);
    assign o_sts.last  = is_last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip      <= '0;
            r_subnet_mask <= '0;
            r_gateway_ip  <= '0;
            r_max_age     <= arpc_pkg::MAX_AGE_RST;
        end else if (i_cfg_we) begin
            unique case (arpc_pkg::t_cfg_idx'(i_cfg_index))
                arpc_pkg::CFG_OWN_IP:      r_own_ip      <= i_cfg_data;
                arpc_pkg::CFG_SUBNET_MASK: r_subnet_mask <= i_cfg_data;
                arpc_pkg::CFG_GATEWAY_IP:  r_gateway_ip  <= i_cfg_data;
                arpc_pkg::CFG_MAX_AGE:     r_max_age     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits and fill pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else begin
            if (i_cmd.learn) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= (r_ptr == LAST_IDX) ? '0 : r_ptr + IW'(1);
            end
            if (i_cmd.scan && slot_expire) begin
                r_valid[r_idx] <= 1'b0;
            end
        end
    end

    // Scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.setup) begin
            r_idx <= '0;
        end else if (i_cmd.scan && !o_sts.match && !is_last) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // Input capture and working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qip <= i_query_ip;
            r_mac <= i_learn_mac;
            r_now <= i_now_sec;
        end
        if (i_cmd.learn) begin
            r_target <= '0;
            r_hit    <= 1'b0;
            r_miss   <= 1'b0;
            r_fmac   <= '0;
        end else if (i_cmd.setup) begin
            r_target <= on_subnet ? r_qip : r_gateway_ip;
            r_hit    <= 1'b0;
            r_miss   <= 1'b0;
            r_fmac   <= '0;
        end else if (i_cmd.scan) begin
            if (o_sts.match) begin
                r_hit  <= 1'b1;
                r_fmac <= live_mac;
            end else if (is_last) begin
                r_miss <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit <= r_hit;
            r_out_req <= r_miss;
            r_out_ip  <= r_target;
            r_out_mac <= r_fmac;
        end
    end

    assign o_hit          = r_out_hit;
    assign o_send_request = r_out_req;
    assign o_resolve_ip   = r_out_ip;
    assign o_found_mac    = r_out_mac;

endmodule

// ----- rtl/core/arpc_ctrl.sv -----
module arpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_opcode,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output arpc_pkg::t_cmd  o_cmd,
    input  arpc_pkg::t_sts  i_sts
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LEARN = 5'b00010,
        S_SETUP = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_opcode == arpc_pkg::OP_LEARN) ? S_LEARN : S_SETUP;
                end
            end
            S_LEARN: begin
                o_cmd.learn = 1'b1;
                n_state = S_DONE;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.match || i_sts.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/arp_cache_with_aging.sv -----
// Lookup: states SETUP, SCAN and DONE follow the accepting edge; SCAN visits 1..ENTRIES
// slots one by one through the single RAM read port, until a match or the last slot.
// Learn: states LEARN and DONE follow the accepting edge, with one RAM write.
// One item in flight; the next beat is taken the cycle after the result is loaded,
// which DONE does only once the output register is free, so output stalls hold it.
// Synchronous active-low reset clears all slots, the fill pointer, scan index and state.
module arp_cache_with_aging #(
    parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_opcode,
    input  logic [arpc_pkg::IP_W-1:0]        i_query_ip,
    input  logic [arpc_pkg::MAC_W-1:0]       i_learn_mac,
    input  logic [arpc_pkg::STAMP_W-1:0]     i_now_sec,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_hit,
    output logic                             o_send_request,
    output logic [arpc_pkg::IP_W-1:0]        o_resolve_ip,
    output logic [arpc_pkg::MAC_W-1:0]       o_found_mac
);

    arpc_pkg::t_cmd cmd;
    arpc_pkg::t_sts sts;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    arpc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_query_ip     (i_query_ip),
        .i_learn_mac    (i_learn_mac),
        .i_now_sec      (i_now_sec),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_hit          (o_hit),
        .o_send_request (o_send_request),
        .o_resolve_ip   (o_resolve_ip),
        .o_found_mac    (o_found_mac)
    );

endmodule

// ----- rtl/core/arpc_chk.sv -----
module arpc_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic                             o_hit,
    input logic                             o_send_request,
    input logic [arpc_pkg::IP_W-1:0]        o_resolve_ip,
    input logic [arpc_pkg::MAC_W-1:0]       o_found_mac
);

    // One item at a time: an accepted beat closes the input next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_resolve_ip) && $stable(o_found_mac)
             && $stable(o_hit)))
        else $error("stalled result beat changed");

    // Hit and request never together
    a_hit_xor_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_send_request))
        else $error("hit and request both set");

    // No MAC without a hit
    a_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_found_mac == '0))
        else $error("MAC given without hit");

endmodule

bind arp_cache_with_aging arpc_chk u_arpc_chk (.*);
